// ===== rtl/slm_pkg.sv =====
// Shared types and constants for the LIKE pattern matcher.
// Used by slm_cell and sql_like_wildcard_matcher; no dependencies.
`default_nettype none

package slm_pkg;

   localparam int PATTERN_MAX = 32;
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

   localparam logic [7:0] CHAR_ANY_RUN = 8'h25;  // '%'
   localparam logic [7:0] CHAR_ANY_ONE = 8'h5F;  // '_'

   typedef enum logic [1:0] {
      CMD_PATTERN = 2'd0,
      CMD_SUBJECT = 2'd1,
      CMD_REPORT  = 2'd2
   } command_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic       first_of_pattern;
   } req_beat_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } rsp_beat_type;

   // Per-cell controls driven from the top level.
   typedef struct packed {
      logic       head;      // position zero: active after restart
      logic       valid;     // position lies below the pattern length
      logic       write;     // store data_byte as this position's pattern byte
      logic       consume;   // advance by one subject byte
      logic       restart;   // drop back to the start of the subject
      logic [7:0] data_byte;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/slm_cell.sv =====
// One pattern position: stored pattern byte and its active bit.
// Depends on slm_pkg; chained by sql_like_wildcard_matcher.
`default_nettype none

module slm_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire slm_pkg::cell_ctrl_type ctrl,
   input  wire logic                  closure_in,  // '%' reach from the left neighbor
   input  wire logic                  step_in,     // byte match from the left neighbor
   output logic                       closure_out,
   output logic                       step_out,
   output logic                       closed
);

   logic [7:0] pat_ff;
   logic       active_ff;
   logic       active_in;
   logic       live;
   logic       is_run;
   logic       is_hit;

   always_comb begin
      closed      = active_ff | closure_in;
      live        = closed & ctrl.valid;
      is_run      = (pat_ff == slm_pkg::CHAR_ANY_RUN);
      is_hit      = (pat_ff == slm_pkg::CHAR_ANY_ONE) || (pat_ff == ctrl.data_byte);
      closure_out = live & is_run;
      step_out    = live & ~is_run & is_hit;
   end

   always_comb begin
      active_in = active_ff;
      if (ctrl.restart) begin
         active_in = ctrl.head;
      end else if (ctrl.consume) begin
         // a '%' keeps itself alive; otherwise the token arrives from the left
         active_in = closure_out | step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ctrl.head;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         pat_ff <= ctrl.data_byte;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sql_like_wildcard_matcher.sv =====
// SQL LIKE matcher top level: command decode, pattern bookkeeping, cell chain.
// Depends on slm_pkg and slm_cell.
//
// Usage: req beats carry a command. Pattern beats (command 0) load the pattern
// one byte at a time, first_of_pattern clearing it; a zero byte closes it.
// Subject beats (command 1) stream subject bytes; a zero byte stops the
// subject. A report beat (command 2) yields one rsp beat with matched and
// pattern_overflow and restarts the subject. Other commands do nothing.
// Throughput: one req beat per cycle, bar a held-off report beat; each subject byte
// updates all pattern cells at once, the '%' closure rippling along the chain.
// Latency: the rsp beat is valid the cycle after its report beat is taken.
// The result sits in an output register; while it is stalled, pattern and
// subject beats are still taken and only a further report beat is held off.
// Reset: pattern empty, overflow clear, only position zero active, no rsp.
`default_nettype none

module sql_like_wildcard_matcher (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire slm_pkg::req_beat_type req_beat,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output slm_pkg::rsp_beat_type      rsp_beat
);

   localparam int MAX   = slm_pkg::PATTERN_MAX;
   localparam int LEN_W = slm_pkg::LEN_W;

   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  overflow_ff, overflow_in;
   logic                  closed_ff, closed_in;
   logic                  stopped_ff, stopped_in;
   logic                  end_active_ff, end_active_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   slm_pkg::rsp_beat_type rsp_beat_ff, rsp_beat_in;

   logic                  accept;
   logic                  do_pattern, do_subject, do_report;
   logic                  consume;
   logic                  pat_write;
   logic [LEN_W-1:0]      eff_len;
   logic                  eff_closed;
   logic                  eff_overflow;

   logic [MAX:0]          closure_chain;
   logic [MAX:0]          step_chain;
   logic [MAX:0]          closed_vec;
   logic [MAX:0]          at_len;
   logic                  hit;

   slm_pkg::cell_ctrl_type cell_ctrl [MAX];

   assign req_stall = rsp_valid_ff && rsp_stall
                      && (req_beat.command == slm_pkg::CMD_REPORT);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      do_pattern = 1'b0;
      do_subject = 1'b0;
      do_report  = 1'b0;
      unique case (req_beat.command)
         slm_pkg::CMD_PATTERN: do_pattern = accept;
         slm_pkg::CMD_SUBJECT: do_subject = accept;
         slm_pkg::CMD_REPORT:  do_report  = accept;
         default: ;
      endcase
   end

   // Pattern bookkeeping, with the clear applied ahead of the byte.
   always_comb begin
      eff_len      = req_beat.first_of_pattern ? '0 : len_ff;
      eff_closed   = req_beat.first_of_pattern ? 1'b0 : closed_ff;
      eff_overflow = req_beat.first_of_pattern ? 1'b0 : overflow_ff;
      len_in       = len_ff;
      closed_in    = closed_ff;
      overflow_in  = overflow_ff;
      pat_write    = 1'b0;
      if (do_pattern) begin
         len_in      = eff_len;
         closed_in   = eff_closed;
         overflow_in = eff_overflow;
         if (!eff_closed) begin
            if (req_beat.data_byte == 8'd0) begin
               closed_in = 1'b1;
            end else if (eff_len == LEN_W'(MAX)) begin
               overflow_in = 1'b1;
            end else begin
               pat_write = 1'b1;
               len_in    = eff_len + LEN_W'(1);
            end
         end
      end
   end

   assign consume = do_subject && !stopped_ff && (req_beat.data_byte != 8'd0);

   always_comb begin
      stopped_in = stopped_ff;
      if (do_pattern || do_report) begin
         stopped_in = 1'b0;
      end else if (do_subject && req_beat.data_byte == 8'd0) begin
         stopped_in = 1'b1;
      end
   end

   assign closure_chain[0] = 1'b0;
   assign step_chain[0]    = 1'b0;

   for (genvar i = 0; i < MAX; i++) begin : g_cell
      always_comb begin
         cell_ctrl[i].head      = (i == 0);
         cell_ctrl[i].valid     = (len_ff > LEN_W'(i));
         cell_ctrl[i].write     = pat_write && (eff_len == LEN_W'(i));
         cell_ctrl[i].consume   = consume;
         cell_ctrl[i].restart   = do_pattern || do_report;
         cell_ctrl[i].data_byte = req_beat.data_byte;
      end

      slm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl[i]),
         .closure_in  (closure_chain[i]),
         .step_in     (step_chain[i]),
         .closure_out (closure_chain[i+1]),
         .step_out    (step_chain[i+1]),
         .closed      (closed_vec[i])
      );
   end

   for (genvar j = 0; j <= MAX; j++) begin : g_at_len
      assign at_len[j] = (len_ff == LEN_W'(j));
   end

   // Position past the last cell: holds no pattern, only the token.
   assign closed_vec[MAX] = end_active_ff | closure_chain[MAX];

   always_comb begin
      end_active_in = end_active_ff;
      if (do_pattern || do_report) begin
         end_active_in = 1'b0;
      end else if (consume) begin
         end_active_in = step_chain[MAX];
      end
   end

   assign hit = |(closed_vec & at_len);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (do_report) begin
         rsp_valid_in                 = 1'b1;
         rsp_beat_in.matched          = hit && !overflow_ff;
         rsp_beat_in.pattern_overflow = overflow_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         overflow_ff   <= 1'b0;
         closed_ff     <= 1'b0;
         stopped_ff    <= 1'b0;
         end_active_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         len_ff        <= len_in;
         overflow_ff   <= overflow_in;
         closed_ff     <= closed_in;
         stopped_ff    <= stopped_in;
         end_active_ff <= end_active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule

`default_nettype wire
